FILE: rtl/rwlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and sizes for the reader-writer lock table engine.
// No dependencies.
package rwlt_pkg;
  localparam int NUM_LOCKS   = 256;
  localparam int LOCK_AW     = 8;
  localparam int HELD_DEPTH  = 64;
  localparam int HELD_AW     = 6;
  localparam int DEPTH_W     = 7;
  localparam int SHARED_BITS = 24;
  localparam int REF_W       = SHARED_BITS + 1;

  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_ACQUIRE = 3'd1;
  localparam logic [2:0] OP_RETRY   = 3'd2;
  localparam logic [2:0] OP_DECLARE = 3'd3;
  localparam logic [2:0] OP_UNDECL  = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;
  localparam logic [2:0] OP_RSINCE  = 3'd6;
  localparam logic [2:0] OP_QUERY   = 3'd7;

  localparam logic [1:0] M_SHARED = 2'd0;
  localparam logic [1:0] M_EXCL   = 2'd1;
  localparam logic [1:0] M_DECL   = 2'd2;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_FULL     = 3'd1;
  localparam logic [2:0] ERR_NOT_DECL = 3'd2;
  localparam logic [2:0] ERR_NOT_HELD = 3'd3;
  localparam logic [2:0] ERR_BAD_SAVE = 3'd4;
  localparam logic [2:0] ERR_BAD_MODE = 3'd5;

  localparam logic [2:0] ACT_REF_UP   = 3'd0;
  localparam logic [2:0] ACT_REF_DOWN = 3'd1;
  localparam logic [2:0] ACT_ATT_SH   = 3'd2;
  localparam logic [2:0] ACT_ATT_EX   = 3'd3;
  localparam logic [2:0] ACT_REL_SH   = 3'd4;
  localparam logic [2:0] ACT_REL_EX   = 3'd5;

  typedef struct packed {
    logic                   waiter;
    logic [REF_W-1:0]       refc;
    logic                   excl;
    logic [SHARED_BITS-1:0] shared;
  } word_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [LOCK_AW-1:0] lock;
  } hent_t;
endpackage
`default_nettype wire

FILE: rtl/rwlt_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared update unit that applies one action to a lock word.
// Depends on rwlt_pkg.
module rwlt_word_unit import rwlt_pkg::*; (
  input  word_t      w_in,
  input  logic [2:0] act,
  output word_t      w_out,
  output logic       grant
);
  logic [REF_W-1:0] ref_dn;

  always_comb begin
    ref_dn = (w_in.refc != '0) ? w_in.refc - 1'b1 : w_in.refc;
    w_out = w_in;
    grant = 1'b0;
    case (act)
      ACT_REF_UP: begin
        if (w_in.refc != '1) w_out.refc = w_in.refc + 1'b1;
      end
      ACT_REF_DOWN: w_out.refc = ref_dn;
      ACT_ATT_EX: begin
        if (w_in.shared == '0 && !w_in.excl) begin
          w_out.excl = 1'b1;
          w_out.waiter = 1'b0;
          grant = 1'b1;
        end else begin
          w_out.waiter = 1'b1;
        end
      end
      ACT_ATT_SH: begin
        if (!w_in.excl && !w_in.waiter && w_in.shared != '1) begin
          w_out.shared = w_in.shared + 1'b1;
          grant = 1'b1;
        end
      end
      ACT_REL_SH: begin
        if (w_in.shared != '0) w_out.shared = w_in.shared - 1'b1;
        w_out.refc = ref_dn;
      end
      ACT_REL_EX: begin
        w_out.excl = 1'b0;
        w_out.refc = ref_dn;
      end
      default: w_out = w_in;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/rwlt_lock_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Lock word table with a registered read port and per-entry valid bits.
// An entry not written since reset reads as zero. Depends on rwlt_pkg.
module rwlt_lock_mem import rwlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [LOCK_AW-1:0] raddr,
  output word_t              rdata,
  input  logic               we,
  input  logic [LOCK_AW-1:0] waddr,
  input  word_t              wdata
);
  word_t                mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] valid;
  word_t                rd_q;
  logic                 vld_q;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid[raddr];
      if (we) valid[waddr] <= 1'b1;
    end
  end

  assign rdata = vld_q ? rd_q : '0;
endmodule
`default_nettype wire

FILE: rtl/rwlt_held_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Held list storage: one write port and one registered read port.
// Depends on rwlt_pkg.
module rwlt_held_mem import rwlt_pkg::*; (
  input  logic               clk,
  input  logic [HELD_AW-1:0] raddr,
  output hent_t              rdata,
  input  logic               we,
  input  logic [HELD_AW-1:0] waddr,
  input  hent_t              wdata
);
  hent_t mem [HELD_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/rw_lock_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Reader-writer lock table engine with a single client's held list.
// Depends on rwlt_pkg, rwlt_word_unit, rwlt_lock_mem and rwlt_held_mem.
//
// One input word carries an operation, a lock index, a mode and a saved
// depth; each one yields exactly one result word on the output channel.
// The block takes one word at a time and holds in_stall high until the
// result has been loaded into the output register.
// Init, query, declare and rejected requests go from the lock read to the
// dispatch and result states; an acquire or retry that makes an attempt
// also passes the attempt state. The input is free again as soon as the
// result is loaded. Undeclare and release search the held list newest first,
// then close the gap by moving each later entry down one place. Release
// since pops entries down to the saved depth, updating each one's lock word.
// This sequencing follows from the single read port of the held list memory
// and the one word update unit that all lock changes but init pass through.
// After reset every lock word reads as zero and the held list is empty.
// A stalled result stays in the output register unchanged; the next word
// may be accepted meanwhile, but its result waits until the register frees.
module rw_lock_table_engine import rwlt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             operation,
  input  logic [LOCK_AW-1:0]     lock_id,
  input  logic [1:0]             mode,
  input  logic [DEPTH_W-1:0]     saved_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   granted,
  output logic [2:0]             error_code,
  output logic [DEPTH_W-1:0]     held_count,
  output logic                   destroyable,
  output logic [SHARED_BITS-1:0] shared_holders,
  output logic                   exclusive_held,
  output logic                   writer_waiting,
  output logic [REF_W-1:0]       reference_count,
  output logic [DEPTH_W-1:0]     released_entries
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_ATT  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SCMP = 4'd5;
  localparam logic [3:0] S_CCHK = 4'd6;
  localparam logic [3:0] S_CWR  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_PCHK = 4'd9;
  localparam logic [3:0] S_PLK  = 4'd10;
  localparam logic [3:0] S_PAPP = 4'd11;
  localparam logic [3:0] S_FRD  = 4'd12;
  localparam logic [3:0] S_RESP = 4'd13;

  logic [3:0]         state;
  logic [2:0]         op;
  logic [LOCK_AW-1:0] k;
  logic [1:0]         md;
  logic [DEPTH_W-1:0] saved;
  logic [DEPTH_W-1:0] depth;
  logic [HELD_AW-1:0] idx;
  logic [HELD_AW-1:0] j;
  word_t              w;
  logic [2:0]         err;
  logic               grant_r;
  logic [DEPTH_W-1:0] popped;
  logic [1:0]         fm;
  logic [LOCK_AW-1:0] lk;
  logic [1:0]         pm;

  word_t              l_rdata, l_wdata, u_in, u_out;
  logic               l_we, u_grant, h_we, full;
  logic [LOCK_AW-1:0] l_raddr, l_waddr;
  logic [HELD_AW-1:0] h_raddr, h_waddr;
  logic [2:0]         act;
  hent_t              h_rdata, h_wdata;
  logic [DEPTH_W-1:0] j_inc;
  logic               resp_load;

  assign in_stall  = (state != S_IDLE);
  assign full      = (depth == DEPTH_W'(HELD_DEPTH));
  assign j_inc     = {1'b0, j} + 1'b1;
  assign resp_load = (state == S_RESP) && (!out_valid || !out_stall);

  rwlt_word_unit u_unit (.w_in(u_in), .act(act), .w_out(u_out), .grant(u_grant));

  rwlt_lock_mem u_lock (
    .clk(clk), .rst(rst), .raddr(l_raddr), .rdata(l_rdata),
    .we(l_we), .waddr(l_waddr), .wdata(l_wdata)
  );

  rwlt_held_mem u_held (
    .clk(clk), .raddr(h_raddr), .rdata(h_rdata),
    .we(h_we), .waddr(h_waddr), .wdata(h_wdata)
  );

  always_comb begin
    u_in = (state == S_PAPP) ? l_rdata : w;
    case (state)
      S_ATT:   act = (md == M_EXCL) ? ACT_ATT_EX : ACT_ATT_SH;
      S_UPD:   act = (op == OP_UNDECL) ? ACT_REF_DOWN :
                     ((fm == M_EXCL) ? ACT_REL_EX : ACT_REL_SH);
      S_PAPP:  act = (pm == M_DECL) ? ACT_REF_DOWN :
                     ((pm == M_EXCL) ? ACT_REL_EX : ACT_REL_SH);
      default: act = ACT_REF_UP;
    endcase

    case (state)
      S_IDLE:  l_raddr = lock_id;
      S_PLK:   l_raddr = h_rdata.lock;
      default: l_raddr = k;
    endcase
    l_we    = 1'b0;
    l_waddr = k;
    l_wdata = u_out;
    h_we    = 1'b0;
    h_waddr = depth[HELD_AW-1:0];
    h_wdata = '{mode: md, lock: k};
    case (state)
      S_SRD:   h_raddr = idx;
      S_CCHK:  h_raddr = j_inc[HELD_AW-1:0];
      default: h_raddr = HELD_AW'(depth - 1'b1);
    endcase

    case (state)
      S_DISP: begin
        if (op == OP_INIT) begin
          l_we = 1'b1;
          l_wdata = '0;
        end else if (op == OP_DECLARE && !full) begin
          l_we = 1'b1;
          h_we = 1'b1;
          h_wdata = '{mode: M_DECL, lock: k};
        end
      end
      S_ATT: begin
        l_we = 1'b1;
        h_we = u_grant;
      end
      S_CWR: begin
        h_we = 1'b1;
        h_waddr = j;
        h_wdata = h_rdata;
      end
      S_UPD: l_we = 1'b1;
      S_PAPP: begin
        l_we = 1'b1;
        l_waddr = lk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (resp_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= operation;
            k       <= lock_id;
            md      <= mode;
            saved   <= saved_count;
            err     <= ERR_OK;
            grant_r <= 1'b0;
            popped  <= '0;
            state   <= S_LRD;
          end
        end
        S_LRD: begin
          w     <= l_rdata;
          state <= S_DISP;
        end
        S_DISP: begin
          state <= S_RESP;
          case (op)
            OP_INIT: w <= '0;
            OP_ACQUIRE, OP_RETRY: begin
              if (md != M_SHARED && md != M_EXCL) err <= ERR_BAD_MODE;
              else if (full) err <= ERR_FULL;
              else begin
                if (op == OP_ACQUIRE) w <= u_out;
                state <= S_ATT;
              end
            end
            OP_DECLARE: begin
              if (full) err <= ERR_FULL;
              else begin
                w     <= u_out;
                depth <= depth + 1'b1;
              end
            end
            OP_UNDECL, OP_RELEASE: begin
              if (depth == '0) begin
                err <= (op == OP_UNDECL) ? ERR_NOT_DECL : ERR_NOT_HELD;
              end else begin
                idx   <= HELD_AW'(depth - 1'b1);
                state <= S_SRD;
              end
            end
            OP_RSINCE: begin
              if (saved > depth) err <= ERR_BAD_SAVE;
              else state <= S_PCHK;
            end
            default: ;
          endcase
        end
        S_ATT: begin
          w       <= u_out;
          grant_r <= u_grant;
          if (u_grant) depth <= depth + 1'b1;
          state   <= S_RESP;
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (h_rdata.lock == k && (op == OP_RELEASE || h_rdata.mode == M_DECL)) begin
            fm    <= h_rdata.mode;
            j     <= idx;
            state <= S_CCHK;
          end else if (idx == '0) begin
            err   <= (op == OP_UNDECL) ? ERR_NOT_DECL : ERR_NOT_HELD;
            state <= S_RESP;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SRD;
          end
        end
        S_CCHK: begin
          if (j_inc < depth) state <= S_CWR;
          else begin
            depth <= depth - 1'b1;
            state <= S_UPD;
          end
        end
        S_CWR: begin
          j     <= j_inc[HELD_AW-1:0];
          state <= S_CCHK;
        end
        S_UPD: begin
          w     <= u_out;
          state <= S_RESP;
        end
        S_PCHK: begin
          if (depth > saved) state <= S_PLK;
          else state <= S_FRD;
        end
        S_PLK: begin
          lk    <= h_rdata.lock;
          pm    <= h_rdata.mode;
          state <= S_PAPP;
        end
        S_PAPP: begin
          depth  <= depth - 1'b1;
          popped <= popped + 1'b1;
          state  <= S_PCHK;
        end
        S_FRD: begin
          w     <= l_rdata;
          state <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            granted          <= grant_r;
            error_code       <= err;
            held_count       <= depth;
            destroyable      <= (w.refc == '0);
            shared_holders   <= w.shared;
            exclusive_held   <= w.excl;
            writer_waiting   <= w.waiter;
            reference_count  <= w.refc;
            released_entries <= popped;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rwlt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the lock table engine's result channel, and the bind
// that attaches them to the top level. Depends on rwlt_pkg.
module rwlt_checker import rwlt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   granted,
  input logic [2:0]             error_code,
  input logic [DEPTH_W-1:0]     held_count,
  input logic                   destroyable,
  input logic [SHARED_BITS-1:0] shared_holders,
  input logic                   exclusive_held,
  input logic [REF_W-1:0]       reference_count,
  input logic [DEPTH_W-1:0]     released_entries
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(held_count) && $stable(reference_count))
    else $error("Stalled result changed.");
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> error_code == ERR_OK)
    else $error("Grant reported with an error.");
  a_grant_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> exclusive_held != (shared_holders != '0))
    else $error("Granted lock is both shared and exclusive, or neither.");
  a_destroy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> destroyable == (reference_count == '0))
    else $error("Destroyable flag disagrees with reference count.");
  a_popped: assert property (@(posedge clk) disable iff (rst)
    out_valid && released_entries != '0 |-> error_code == ERR_OK && !granted)
    else $error("Entries popped on a failed operation.");
endmodule

bind rw_lock_table_engine rwlt_checker u_rwlt_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .granted(granted), .error_code(error_code), .held_count(held_count),
  .destroyable(destroyable), .shared_holders(shared_holders),
  .exclusive_held(exclusive_held), .reference_count(reference_count),
  .released_entries(released_entries)
);
`default_nettype wire
